### design/msp_pkg.sv
package msp_pkg;

    localparam int PULSE_W  = 31;
    localparam int CLOCKS_W = 31;
    localparam int TARGET_W = 12;
    localparam int DUTY_W   = 32;
    localparam int HZ_W     = 26;
    localparam int PROD_W   = PULSE_W + HZ_W;
    localparam int FF_W     = 21;
    localparam int FFP_W    = TARGET_W + FF_W;
    localparam int ERR_W    = 11;
    localparam int STEP_W   = 29;
    localparam int SUM_W    = DUTY_W + 2;

    localparam logic [DUTY_W-1:0] DUTY_FULL   = 32'hFFFF_FFFF;
    localparam logic [DUTY_W-1:0] DUTY_MIN    = 32'd1288490160;
    localparam logic [FF_W-1:0]   FF_GAIN     = 21'd1342177;
    localparam logic [HZ_W-1:0]   CLOCK_HZ    = 26'd48000000;
    localparam int                ERR_LIMIT   = 1000;
    localparam int                P_GAIN      = 100000;
    localparam int                SETTLE_BAND = 100;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                meas;
        logic                div_zero;
        logic [PROD_W-1:0]   prod;
        logic [CLOCKS_W-1:0] clocks;
    } t_entry;

endpackage

### design/msp_front.sv
module msp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [msp_pkg::PULSE_W-1:0]   i_pulse_count,
    input  logic [msp_pkg::CLOCKS_W-1:0]  i_clock_count,
    input  logic                          i_full,
    output logic                          o_push,
    output msp_pkg::t_entry               o_entry
);

    logic            r_valid;
    msp_pkg::t_entry r_entry;
    logic            accept;

    assign o_push     = r_valid && !i_full;
    assign o_in_ready = !r_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_entry    = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // pulse count scaled by the 48 MHz reference, registered before the queue
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.meas     <= i_req_type;
            r_entry.div_zero <= (i_clock_count == '0);
            r_entry.prod     <= msp_pkg::PROD_W'(i_pulse_count)
                                * msp_pkg::PROD_W'(msp_pkg::CLOCK_HZ);
            r_entry.clocks   <= i_clock_count;
        end
    end

endmodule

### design/msp_fifo.sv
module msp_fifo #(
    parameter int DEPTH = msp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msp_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output msp_pkg::t_entry o_data,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msp_pkg::t_entry    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/msp_back.sv
module msp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [msp_pkg::TARGET_W-1:0]  i_cfg_data,
    input  logic                          i_empty,
    input  msp_pkg::t_entry               i_entry,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [msp_pkg::DUTY_W-1:0]    o_duty_word,
    output logic [msp_pkg::DUTY_W-1:0]    o_speed_rpm,
    output logic                          o_settled
);

    localparam int PROD_W = msp_pkg::PROD_W;
    localparam int DIV_W  = msp_pkg::CLOCKS_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int DW     = msp_pkg::DUTY_W;
    localparam int SW     = msp_pkg::SUM_W;
    localparam int EW     = msp_pkg::ERR_W;
    localparam int TW     = msp_pkg::STEP_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RPM  = 5'b00100,
        S_ERR  = 5'b01000,
        S_DUTY = 5'b10000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [msp_pkg::TARGET_W-1:0]  r_target;
    logic [DW-1:0]                 r_duty;
    logic                          r_meas;
    logic                          r_zero;
    logic [DIV_W-1:0]              r_div;
    logic [DIV_W-1:0]              r_rem;
    logic [PROD_W-1:0]             r_quo;
    logic [CNT_W-1:0]              r_cnt;
    logic [DW-1:0]                 r_rpm;
    logic signed [TW-1:0]          r_step;
    logic                          r_settled;
    logic [msp_pkg::FFP_W-1:0]     r_ff;
    logic                          r_out_valid;
    logic [DW-1:0]                 r_out_duty;
    logic [DW-1:0]                 r_out_rpm;
    logic                          r_out_settled;

    logic                          out_free;
    logic [DIV_W:0]                trial;
    logic [DIV_W:0]                diff;
    logic                          ge;
    logic [PROD_W-1:0]             q_m1;
    logic [DW-3:0]                 quarter;
    logic [DW+3:0]                 times60;
    logic [DW-1:0]                 rpm_c;
    logic signed [SW-1:0]          err_full;
    logic signed [EW-1:0]          err_c;
    logic signed [TW-1:0]          step_c;
    logic signed [SW-1:0]          sum;
    logic [DW-1:0]                 ff_sat;
    logic [DW-1:0]                 duty_c;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_duty_word = r_out_duty;
    assign o_speed_rpm = r_out_rpm;
    assign o_settled   = r_out_settled;

    // restoring divider, one quotient bit per cycle
    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    assign q_m1    = r_quo - PROD_W'(1);
    assign quarter = q_m1[DW-1:2];
    assign times60 = {quarter, 6'b0} - {4'b0, quarter, 2'b0};

    always_comb begin
        if (r_zero || (r_quo > PROD_W'(msp_pkg::DUTY_FULL) + PROD_W'(1))) begin
            rpm_c = msp_pkg::DUTY_FULL;
        end else if (r_quo == '0) begin
            rpm_c = '0;
        end else if (times60[DW+3:DW] != '0) begin
            rpm_c = msp_pkg::DUTY_FULL;
        end else begin
            rpm_c = times60[DW-1:0];
        end
    end

    assign err_full = $signed(SW'(r_target)) - $signed(SW'(r_rpm));

    always_comb begin
        if (err_full > $signed(SW'(msp_pkg::ERR_LIMIT))) begin
            err_c = EW'(msp_pkg::ERR_LIMIT);
        end else if (err_full < -$signed(SW'(msp_pkg::ERR_LIMIT))) begin
            err_c = -EW'(msp_pkg::ERR_LIMIT);
        end else begin
            err_c = err_full[EW-1:0];
        end
    end

    assign step_c = TW'(err_c) * $signed(TW'(msp_pkg::P_GAIN));

    assign sum    = $signed({2'b0, r_duty}) + SW'(r_step);
    assign ff_sat = (r_ff[msp_pkg::FFP_W-1:DW] != '0) ? msp_pkg::DUTY_FULL : r_ff[DW-1:0];

    always_comb begin
        if (r_meas) begin
            if (sum > $signed({2'b0, msp_pkg::DUTY_FULL})) begin
                duty_c = msp_pkg::DUTY_FULL;
            end else if (sum < $signed({2'b0, msp_pkg::DUTY_MIN})) begin
                duty_c = msp_pkg::DUTY_MIN;
            end else begin
                duty_c = sum[DW-1:0];
            end
        end else begin
            duty_c = (ff_sat < msp_pkg::DUTY_MIN) ? msp_pkg::DUTY_MIN : ff_sat;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (!i_entry.meas) begin
                        n_state = S_ERR;
                    end else if (i_entry.div_zero) begin
                        n_state = S_RPM;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_RPM;
                end
            end
            S_RPM:  n_state = S_ERR;
            S_ERR:  n_state = S_DUTY;
            S_DUTY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_duty      <= msp_pkg::DUTY_MIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if ((r_state == S_DUTY) && out_free) begin
                r_duty      <= duty_c;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_meas <= i_entry.meas;
                    r_zero <= i_entry.div_zero;
                    r_div  <= i_entry.clocks;
                    r_quo  <= i_entry.prod;
                    r_rem  <= '0;
                    r_cnt  <= CNT_W'(PROD_W - 1);
                    r_rpm  <= '0;
                end
            end
            S_DIV: begin
                r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_quo <= {r_quo[PROD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_RPM: begin
                r_rpm <= rpm_c;
            end
            S_ERR: begin
                r_step    <= step_c;
                r_settled <= r_meas && (err_c <= $signed(EW'(msp_pkg::SETTLE_BAND)))
                             && (err_c >= -$signed(EW'(msp_pkg::SETTLE_BAND)));
                r_ff      <= msp_pkg::FFP_W'(r_target)
                             * msp_pkg::FFP_W'(msp_pkg::FF_GAIN);
            end
            S_DUTY: begin
                if (out_free) begin
                    r_out_duty    <= duty_c;
                    r_out_rpm     <= r_rpm;
                    r_out_settled <= r_settled;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### design/motor_speed_p_loop.sv
// Proportional speed regulator for a brushless motor. A start transaction
// (req_type 0) loads the duty word with 1342177 times target_speed, floored at
// 30 percent; a measurement transaction (req_type 1) converts the pulse and
// 48 MHz clock counts to rpm, clamps the speed error to +/-1000 and adds it,
// times 100000, to the duty word, which stays between 30 percent and full
// scale. In the back end a measurement runs through the radix-2 divider, which
// retires one of 57 quotient bits per cycle; a start transaction, or a
// measurement with a zero clock count, skips the divider. Inputs are accepted
// into a two-entry queue while the back end works, and a finished result
// waits in an output register. target_speed is written via i_cfg_we /
// i_cfg_data, by the user only while the block is idle (not enforced).
module motor_speed_p_loop #(
    parameter int QUEUE_DEPTH = msp_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [msp_pkg::TARGET_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [msp_pkg::PULSE_W-1:0]   i_pulse_count,
    input  logic [msp_pkg::CLOCKS_W-1:0]  i_clock_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [msp_pkg::DUTY_W-1:0]    o_duty_word,
    output logic [msp_pkg::DUTY_W-1:0]    o_speed_rpm,
    output logic                          o_settled
);

    msp_pkg::t_entry push_entry;
    msp_pkg::t_entry pop_entry;
    logic            push;
    logic            full;
    logic            pop;
    logic            empty;

    msp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pulse_count (i_pulse_count),
        .i_clock_count (i_clock_count),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    msp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_empty (empty)
    );

    msp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (empty),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_duty_word (o_duty_word),
        .o_speed_rpm (o_speed_rpm),
        .o_settled   (o_settled)
    );

endmodule

### tb/sv/tb.sv
module tb;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_MEAS  = 1'b1;
    localparam logic [msp_pkg::CLOCKS_W-1:0] ONE_SECOND = 31'd48000000;
    localparam logic [msp_pkg::PULSE_W-1:0]  PULSE_MAX  = 31'h7FFF_FFFF;
    localparam logic [msp_pkg::CLOCKS_W-1:0] CLOCKS_MAX = 31'h7FFF_FFFF;

    typedef struct {
        logic [msp_pkg::DUTY_W-1:0] duty;
        logic [msp_pkg::DUTY_W-1:0] rpm;
        logic                       settled;
    } t_regulator_out;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [msp_pkg::TARGET_W-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         req_type = 1'b0;
    logic [msp_pkg::PULSE_W-1:0]  pulse_count = '0;
    logic [msp_pkg::CLOCKS_W-1:0] clock_count = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [msp_pkg::DUTY_W-1:0]   duty_word;
    logic [msp_pkg::DUTY_W-1:0]   speed_rpm;
    logic                         settled;

    logic [msp_pkg::TARGET_W-1:0] model_target;
    logic [msp_pkg::DUTY_W-1:0]   model_duty;
    t_regulator_out               pending_outputs[$];
    t_regulator_out               want;
    int                           mismatch_count = 0;
    bit                           idle_en = 1'b1;
    int                           hold_left = 0;
    int                           rx_gap = 0;

    motor_speed_p_loop uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_pulse_count (pulse_count),
        .i_clock_count (clock_count),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_duty_word   (duty_word),
        .o_speed_rpm   (speed_rpm),
        .o_settled     (settled)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [msp_pkg::DUTY_W-1:0] rpm_from_counts(
            logic [msp_pkg::PULSE_W-1:0] pulses, logic [msp_pkg::CLOCKS_W-1:0] clocks);
        logic [63:0] q;
        logic [63:0] v;
        logic [63:0] r;
        if (clocks == 0)
            return msp_pkg::DUTY_FULL;
        q = ({33'd0, pulses} * {38'd0, msp_pkg::CLOCK_HZ}) / {33'd0, clocks};
        if (q == 0)
            return '0;
        v = q - 64'd1;
        if (v > {32'd0, msp_pkg::DUTY_FULL})
            return msp_pkg::DUTY_FULL;
        r = (v / 64'd4) * 64'd60;
        if (r > {32'd0, msp_pkg::DUTY_FULL})
            return msp_pkg::DUTY_FULL;
        return r[msp_pkg::DUTY_W-1:0];
    endfunction

    function automatic logic [msp_pkg::DUTY_W-1:0] clamp_duty(longint d);
        longint full_l;
        longint min_l;
        full_l = longint'(msp_pkg::DUTY_FULL);
        min_l = longint'(msp_pkg::DUTY_MIN);
        if (d > full_l)
            return msp_pkg::DUTY_FULL;
        if (d < min_l)
            return msp_pkg::DUTY_MIN;
        return d[msp_pkg::DUTY_W-1:0];
    endfunction

    task automatic predict_regulator(logic kind, logic [msp_pkg::PULSE_W-1:0] pulses,
                                     logic [msp_pkg::CLOCKS_W-1:0] clocks);
        t_regulator_out r;
        logic [63:0]    ff;
        longint         tgt;
        longint         meas;
        longint         err;
        longint         acc;
        if (kind == REQ_START) begin
            ff = {43'd0, msp_pkg::FF_GAIN} * {52'd0, model_target};
            if (ff > {32'd0, msp_pkg::DUTY_FULL})
                ff = {32'd0, msp_pkg::DUTY_FULL};
            model_duty = clamp_duty(longint'(ff));
            r.rpm = '0;
            r.settled = 1'b0;
        end else begin
            r.rpm = rpm_from_counts(pulses, clocks);
            tgt = longint'(model_target);
            meas = longint'(r.rpm);
            err = tgt - meas;
            if (err > msp_pkg::ERR_LIMIT)
                err = msp_pkg::ERR_LIMIT;
            else if (err < -msp_pkg::ERR_LIMIT)
                err = -msp_pkg::ERR_LIMIT;
            acc = longint'(model_duty);
            model_duty = clamp_duty(acc + err * msp_pkg::P_GAIN);
            r.settled = ((err < 0) ? -err : err) <= msp_pkg::SETTLE_BAND;
        end
        r.duty = model_duty;
        pending_outputs.push_back(r);
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction duty=%0d rpm=%0d",
                                          duty_word, speed_rpm));
            end else begin
                want = pending_outputs.pop_front();
                if (duty_word !== want.duty)
                    report_mismatch($sformatf("duty_word got %0d want %0d",
                                              duty_word, want.duty));
                if (speed_rpm !== want.rpm)
                    report_mismatch($sformatf("speed_rpm got %0d want %0d",
                                              speed_rpm, want.rpm));
                if (settled !== want.settled)
                    report_mismatch($sformatf("settled got %0b want %0b",
                                              settled, want.settled));
            end
        end
    end

    // receiver: long hold on request, else random stall bursts
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic kind, logic [msp_pkg::PULSE_W-1:0] pulses,
                             logic [msp_pkg::CLOCKS_W-1:0] clocks);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        pulse_count <= pulses;
        clock_count <= clocks;
        do @(posedge clk); while (!in_ready);
        predict_regulator(kind, pulses, clocks);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_target(logic [msp_pkg::TARGET_W-1:0] speed);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= speed;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_target = speed;
    endtask

    // pulse count that lands the measured speed near a given rpm
    function automatic logic [msp_pkg::PULSE_W-1:0] pulses_for_speed(int rpm,
            logic [msp_pkg::CLOCKS_W-1:0] clocks);
        logic [63:0] q;
        logic [63:0] p;
        if (rpm < 0)
            return '0;
        q = 64'(rpm / 15 + 1);
        p = (q * {33'd0, clocks}) / {38'd0, msp_pkg::CLOCK_HZ};
        return p[msp_pkg::PULSE_W-1:0];
    endfunction

    task automatic test_start_duty();
        logic [msp_pkg::TARGET_W-1:0] speeds[6];
        speeds = '{12'd0, 12'd960, 12'd961, 12'd3200, 12'd3201, 12'd4095};
        foreach (speeds[i]) begin
            write_target(speeds[i]);
            send_item(REQ_START, PULSE_MAX, CLOCKS_MAX);
        end
    endtask

    task automatic test_speed_corners();
        write_target(12'd3200);
        send_item(REQ_MEAS, 31'd1, 31'd0);
        send_item(REQ_MEAS, 31'd0, ONE_SECOND);
        send_item(REQ_MEAS, 31'd0, ONE_SECOND);
        send_item(REQ_MEAS, 31'd1, ONE_SECOND);
        send_item(REQ_MEAS, PULSE_MAX, CLOCKS_MAX);
        send_item(REQ_MEAS, PULSE_MAX, 31'd1);
        send_item(REQ_MEAS, 31'd5, 31'd1);
        send_item(REQ_MEAS, 31'd6, 31'd1);
        send_item(REQ_MEAS, 31'd0, 31'd0);
        write_target(12'd0);
        send_item(REQ_START, 31'd0, 31'd0);
        send_item(REQ_MEAS, PULSE_MAX, 31'd1);
    endtask

    task automatic test_settle_band();
        write_target(12'd1540);
        send_item(REQ_MEAS, 31'd97, ONE_SECOND);
        write_target(12'd1541);
        send_item(REQ_MEAS, 31'd97, ONE_SECOND);
        write_target(12'd1520);
        send_item(REQ_MEAS, 31'd109, ONE_SECOND);
        send_item(REQ_MEAS, 31'd101, ONE_SECOND);
    endtask

    task automatic test_output_stall();
        logic [msp_pkg::CLOCKS_W-1:0] c;
        write_target(12'd1500);
        idle_en = 1'b0;
        hold_left = 600;
        for (int i = 0; i < 12; i++) begin
            c = msp_pkg::CLOCKS_W'($urandom_range(4_000_000, 2_000_000_000));
            send_item((i % 3 == 0) ? REQ_START : REQ_MEAS,
                      pulses_for_speed(1500 + i * 20 - 120, c), c);
        end
        wait_idle();
        idle_en = 1'b1;
    endtask

    task automatic send_random_item();
        int                           pick;
        int                           speed;
        logic                         kind;
        logic [msp_pkg::PULSE_W-1:0]  p;
        logic [msp_pkg::CLOCKS_W-1:0] c;
        pick = $urandom_range(0, 99);
        kind = REQ_MEAS;
        p = msp_pkg::PULSE_W'($urandom);
        c = msp_pkg::CLOCKS_W'($urandom);
        if (pick < 8) begin
            kind = REQ_START;
        end else if (pick < 50) begin
            c = msp_pkg::CLOCKS_W'($urandom_range(4_000_000, 2_000_000_000));
            speed = int'(model_target) + int'($urandom_range(0, 600)) - 300;
            p = pulses_for_speed(speed, c);
        end else if (pick >= 65 && pick < 80) begin
            p = msp_pkg::PULSE_W'($urandom_range(0, 255));
            c = msp_pkg::CLOCKS_W'($urandom_range(0, 255));
        end else if (pick >= 80) begin
            p = msp_pkg::PULSE_W'($urandom >> $urandom_range(0, 31));
            c = msp_pkg::CLOCKS_W'($urandom >> $urandom_range(0, 31));
        end
        send_item(kind, p, c);
    endtask

    task automatic test_random();
        logic [msp_pkg::TARGET_W-1:0] speed;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: speed = 12'd0;
                1: speed = 12'd4095;
                2: speed = 12'd3200;
                default: speed = msp_pkg::TARGET_W'($urandom_range(0, 4095));
            endcase
            write_target(speed);
            if (ph >= 10)
                idle_en = 1'b0;
            repeat (75) send_random_item();
        end
    endtask

    initial begin
        model_target = '0;
        model_duty = msp_pkg::DUTY_MIN;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_start_duty();
        test_speed_corners();
        test_settle_band();
        test_output_stall();
        test_random();
        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
